### hdl/fbm_pkg.sv
`default_nettype none

package fbm_pkg;

    // Field and register widths
    localparam int COORD_W    = 32;
    localparam int NOISE_W    = 16;
    localparam int OCT_W      = 4;
    localparam int PERSIST_W  = 17;
    localparam int LACUN_W    = 20;
    localparam int SEED_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Internal number formats
    localparam int FREQ_W   = 31;
    localparam int AMP_W    = 40;
    localparam int AMPSUM_W = 45;
    localparam int TOTAL_W  = 64;
    localparam int NZ_W     = 20;
    localparam int FADE_W   = 20;

    localparam logic [31:0]         HASH_MUL = 32'h045d_9f3b;
    localparam logic [FREQ_W-1:0]   ONE_FREQ = 31'd65536;
    localparam logic [AMP_W-1:0]    ONE_AMP  = 40'd65536;
    localparam logic [FREQ_W-1:0]   FREQ_CAP = '1;
    localparam logic [AMP_W-1:0]    AMP_CAP  = '1;
    localparam logic signed [NOISE_W-1:0] NOISE_MAX = 16'sh7fff;
    localparam logic signed [NOISE_W-1:0] NOISE_MIN = 16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OCTAVE_COUNT = 2'd0,
        REG_PERSISTENCE  = 2'd1,
        REG_LACUNARITY   = 2'd2,
        REG_HASH_SEED    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } sample_t;

    typedef struct packed {
        logic signed [NOISE_W-1:0] noise_value;
    } result_t;

    // Data handed from one octave cell to the next
    typedef struct packed {
        logic                       valid;
        sample_t                    pt;
        logic [FREQ_W-1:0]          freq;
        logic [AMP_W-1:0]           amp;
        logic signed [TOTAL_W-1:0]  total;
        logic [AMPSUM_W-1:0]        ampsum;
    } octave_link_t;

    // Xor with the arithmetic right shift by 16
    function automatic logic [31:0] mix_pre(input logic [31:0] v);
        return {{16{v[31]}}, v[31:16]} ^ v;
    endfunction

    function automatic logic [31:0] mix_mul(input logic [31:0] v);
        logic [31:0] r;
        r = mix_pre(v) * HASH_MUL;
        return r;
    endfunction

    // Dot product with one of the sixteen gradients
    function automatic logic signed [NZ_W-1:0] grad_dot(
        input logic [3:0]         g,
        input logic signed [17:0] x,
        input logic signed [17:0] y,
        input logic signed [17:0] z
    );
        logic signed [NZ_W-1:0] u;
        logic signed [NZ_W-1:0] v;
        u = g[3] ? NZ_W'(y) : NZ_W'(x);
        if (g[3:2] == 2'b00)
        begin
            v = NZ_W'(y);
        end
        else if (g[3:2] == 2'b11 && !g[0])
        begin
            v = NZ_W'(x);
        end
        else
        begin
            v = NZ_W'(z);
        end
        if (g[0])
        begin
            u = -u;
        end
        if (g[1])
        begin
            v = -v;
        end
        return u + v;
    endfunction

endpackage

`default_nettype wire

### hdl/fbm_stream_if.sv
`default_nettype none

interface fbm_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/fbm_octave_cell.sv
`default_nettype none

module fbm_octave_cell #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic                               active,
    input  logic [fbm_pkg::PERSIST_W-1:0]      persistence,
    input  logic [fbm_pkg::LACUN_W-1:0]        lacunarity,
    input  logic [fbm_pkg::SEED_W-1:0]         hash_seed,
    input  fbm_pkg::octave_link_t              link_in,
    output fbm_pkg::octave_link_t              link_out
);
    localparam int FB     = COORD_FRAC_BITS;
    localparam int FR_SH  = (FB >= 16) ? FB - 16 : 0;
    localparam int FL_SH  = (FB < 16) ? 16 - FB : 0;
    localparam int STAGES = 9;
    localparam int CRY_N  = 7;
    localparam logic [63:0] FRAC_MASK = (64'd1 << FB) - 64'd1;

    typedef struct packed {
        fbm_pkg::sample_t                       pt;
        logic [fbm_pkg::FREQ_W-1:0]             freq_n;
        logic [fbm_pkg::AMP_W-1:0]              amp_n;
        logic [fbm_pkg::AMP_W-1:0]              amp;
        logic signed [fbm_pkg::TOTAL_W-1:0]     total;
        logic [fbm_pkg::AMPSUM_W-1:0]           ampsum;
    } carry_t;

    logic [STAGES-1:0] vld_reg;

    // Stage 1 registers
    logic signed [63:0]                 prod_reg [3];
    logic signed [63:0]                 prod_next [3];
    logic [50:0]                        fprod_f_reg;
    logic [56:0]                        aprod_reg;
    fbm_pkg::sample_t                   pt1_reg;
    logic [fbm_pkg::AMP_W-1:0]          amp1_reg;
    logic signed [fbm_pkg::TOTAL_W-1:0] total1_reg;
    logic [fbm_pkg::AMPSUM_W-1:0]       ampsum1_reg;

    // Stage 2..8 side band
    carry_t cry_reg [CRY_N];
    carry_t cry_next;

    // Stage 2 registers
    logic signed [63:0] s_ax [3];
    logic [31:0]        idx_ax [3];
    logic [15:0]        frac_next [3];
    logic [31:0]        mixa_next [6];
    logic [31:0]        mixa_reg [6];
    logic [15:0]        frac2_reg [3];
    logic [31:0]        aa_reg [3];
    logic [34:0]        freq_wide;
    logic [40:0]        amp_wide;

    // Stage 3 registers
    logic [31:0]        mixb_reg [6];
    logic [15:0]        frac3_reg [3];
    logic [31:0]        t3p_reg [3];
    logic [19:0]        p_reg [3];
    logic [34:0]        six_aa [3];
    logic [20:0]        p_wide [3];

    // Stage 4 registers
    logic [31:0]                        hx [6];
    logic signed [17:0]                 off0 [3];
    logic signed [17:0]                 off1 [3];
    logic signed [fbm_pkg::NZ_W-1:0]    dot_next [8];
    logic signed [fbm_pkg::NZ_W-1:0]    dot_reg [8];
    logic [35:0]                        fprod_reg [3];

    // Stages 5..8 registers
    logic signed [fbm_pkg::NZ_W:0]      diff_x [4];
    logic signed [41:0]                 prodx_reg [4];
    logic signed [fbm_pkg::NZ_W-1:0]    base5_reg [4];
    logic [fbm_pkg::FADE_W-1:0]         fv5_reg;
    logic [fbm_pkg::FADE_W-1:0]         fw5_reg;
    logic signed [fbm_pkg::NZ_W-1:0]    lx [4];
    logic signed [fbm_pkg::NZ_W:0]      diff_y [2];
    logic signed [41:0]                 prody_reg [2];
    logic signed [fbm_pkg::NZ_W-1:0]    base6_reg [2];
    logic [fbm_pkg::FADE_W-1:0]         fw6_reg;
    logic signed [fbm_pkg::NZ_W-1:0]    ly [2];
    logic signed [fbm_pkg::NZ_W:0]      diff_z;
    logic signed [41:0]                 prodz_reg;
    logic signed [fbm_pkg::NZ_W-1:0]    base7_reg;
    logic signed [fbm_pkg::NZ_W-1:0]    nz;
    logic signed [40:0]                 lo_reg;
    logic signed [40:0]                 hi_reg;

    // Stage 9 output
    logic signed [fbm_pkg::TOTAL_W-1:0] contrib;
    fbm_pkg::octave_link_t              out_reg;
    fbm_pkg::octave_link_t              out_next;

    // Advance the valid bits with the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], link_in.valid};
        end
    end

    // Stage 1: scale the point by the frequency, step frequency and amplitude
    always_comb
    begin
        prod_next[0] = link_in.pt.coord_x * $signed({1'b0, link_in.freq});
        prod_next[1] = link_in.pt.coord_y * $signed({1'b0, link_in.freq});
        prod_next[2] = link_in.pt.coord_z * $signed({1'b0, link_in.freq});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg    <= prod_next;
            fprod_f_reg <= 51'(link_in.freq) * 51'(lacunarity);
            aprod_reg   <= 57'(link_in.amp) * 57'(persistence);
            pt1_reg     <= link_in.pt;
            amp1_reg    <= link_in.amp;
            total1_reg  <= link_in.total;
            ampsum1_reg <= link_in.ampsum;
        end
    end

    // Stage 2: split into lattice index and fraction, first hash round
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            s_ax[a]      = prod_reg[a] >>> 16;
            idx_ax[a]    = s_ax[a][FB+31:FB];
            frac_next[a] = 16'(((s_ax[a] & FRAC_MASK) >> FR_SH) << FL_SH);
            mixa_next[2*a]   = fbm_pkg::mix_mul(idx_ax[a]);
            mixa_next[2*a+1] = fbm_pkg::mix_mul(idx_ax[a] + 32'd1);
        end
        freq_wide = fprod_f_reg[50:16];
        amp_wide  = aprod_reg[56:16];
        cry_next.pt     = pt1_reg;
        cry_next.freq_n = (freq_wide > 35'(fbm_pkg::FREQ_CAP)) ? fbm_pkg::FREQ_CAP
                                                               : freq_wide[30:0];
        cry_next.amp_n  = (amp_wide > 41'(fbm_pkg::AMP_CAP)) ? fbm_pkg::AMP_CAP
                                                             : amp_wide[39:0];
        cry_next.amp    = amp1_reg;
        cry_next.total  = total1_reg;
        cry_next.ampsum = ampsum1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mixa_reg  <= mixa_next;
            frac2_reg <= frac_next;
            for (int a = 0; a < 3; a++)
            begin
                aa_reg[a] <= 32'(frac_next[a]) * 32'(frac_next[a]);
            end
            cry_reg[0] <= cry_next;
            for (int k = 1; k < CRY_N; k++)
            begin
                cry_reg[k] <= cry_reg[k-1];
            end
        end
    end

    // Stage 3: second hash round, fade cube and polynomial
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            six_aa[a] = 35'(aa_reg[a]) * 35'd6;
            p_wide[a] = 21'd655360 + 21'(six_aa[a][34:16]) - 21'(frac2_reg[a]) * 21'd15;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int m = 0; m < 6; m++)
            begin
                mixb_reg[m] <= fbm_pkg::mix_mul(mixa_reg[m]);
            end
            for (int a = 0; a < 3; a++)
            begin
                t3p_reg[a]   <= 32'(aa_reg[a][31:16]) * 32'(frac2_reg[a]);
                p_reg[a]     <= p_wide[a][19:0];
                frac3_reg[a] <= frac2_reg[a];
            end
        end
    end

    // Stage 4: corner hashes and gradient dot products, fade product
    always_comb
    begin
        logic [2:0]  cb;
        logic [31:0] hsh;
        for (int m = 0; m < 6; m++)
        begin
            hx[m] = fbm_pkg::mix_pre(mixb_reg[m]);
        end
        for (int a = 0; a < 3; a++)
        begin
            off0[a] = $signed({2'b00, frac3_reg[a]});
            off1[a] = off0[a] - 18'sd65536;
        end
        for (int c = 0; c < 8; c++)
        begin
            cb  = 3'(c);
            hsh = (hx[{2'b00, cb[0]}] ^ hx[3'd2 + {2'b00, cb[1]}] ^ hx[3'd4 + {2'b00, cb[2]}])
                  + hash_seed;
            dot_next[c] = fbm_pkg::grad_dot(hsh[3:0],
                                            cb[0] ? off1[0] : off0[0],
                                            cb[1] ? off1[1] : off0[1],
                                            cb[2] ? off1[2] : off0[2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dot_reg <= dot_next;
            for (int a = 0; a < 3; a++)
            begin
                fprod_reg[a] <= 36'(t3p_reg[a][31:16]) * 36'(p_reg[a]);
            end
        end
    end

    // Stage 5: interpolation weights along x
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            diff_x[i] = (fbm_pkg::NZ_W+1)'(dot_reg[2*i+1]) - (fbm_pkg::NZ_W+1)'(dot_reg[2*i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                prodx_reg[i] <= diff_x[i] * $signed({1'b0, fprod_reg[0][35:16]});
                base5_reg[i] <= dot_reg[2*i];
            end
            fv5_reg <= fprod_reg[1][35:16];
            fw5_reg <= fprod_reg[2][35:16];
        end
    end

    // Stage 6: finish x, weight along y
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            lx[i] = base5_reg[i] + fbm_pkg::NZ_W'(prodx_reg[i] >>> 16);
        end
        for (int j = 0; j < 2; j++)
        begin
            diff_y[j] = (fbm_pkg::NZ_W+1)'(lx[2*j+1]) - (fbm_pkg::NZ_W+1)'(lx[2*j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 2; j++)
            begin
                prody_reg[j] <= diff_y[j] * $signed({1'b0, fv5_reg});
                base6_reg[j] <= lx[2*j];
            end
            fw6_reg <= fw5_reg;
        end
    end

    // Stage 7: finish y, weight along z
    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            ly[j] = base6_reg[j] + fbm_pkg::NZ_W'(prody_reg[j] >>> 16);
        end
        diff_z = (fbm_pkg::NZ_W+1)'(ly[1]) - (fbm_pkg::NZ_W+1)'(ly[0]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prodz_reg <= diff_z * $signed({1'b0, fw6_reg});
            base7_reg <= ly[0];
        end
    end

    // Stage 8: octave noise times amplitude, as two partial products
    assign nz = base7_reg + fbm_pkg::NZ_W'(prodz_reg >>> 16);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_reg <= nz * $signed({1'b0, cry_reg[CRY_N-2].amp[19:0]});
            hi_reg <= nz * $signed({1'b0, cry_reg[CRY_N-2].amp[39:20]});
        end
    end

    // Stage 9: accumulate when this octave is in use
    always_comb
    begin
        contrib = (fbm_pkg::TOTAL_W'(hi_reg) <<< 20) + fbm_pkg::TOTAL_W'(lo_reg);
        out_next.valid  = 1'b0;
        out_next.pt     = cry_reg[CRY_N-1].pt;
        out_next.freq   = cry_reg[CRY_N-1].freq_n;
        out_next.amp    = cry_reg[CRY_N-1].amp_n;
        out_next.total  = active ? cry_reg[CRY_N-1].total + contrib
                                 : cry_reg[CRY_N-1].total;
        out_next.ampsum = active ? cry_reg[CRY_N-1].ampsum
                                   + fbm_pkg::AMPSUM_W'(cry_reg[CRY_N-1].amp)
                                 : cry_reg[CRY_N-1].ampsum;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        link_out       = out_reg;
        link_out.valid = vld_reg[STAGES-1];
    end

endmodule

`default_nettype wire

### hdl/fbm_div_pipe.sv
`default_nettype none

module fbm_div_pipe (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  fbm_pkg::octave_link_t               link_in,
    output logic                                out_valid,
    output logic signed [fbm_pkg::NOISE_W-1:0]  out_value
);
    localparam int QUO_W = 17;
    localparam int DEN_W = fbm_pkg::AMPSUM_W + 2;
    localparam int REM_W = 65;

    typedef struct packed {
        logic             neg;
        logic             ovf;
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } div_state_t;

    logic [QUO_W:0] vld_reg;
    div_state_t     st_reg  [QUO_W+1];
    div_state_t     st_next [QUO_W+1];
    logic [63:0]    mag;

    // Take magnitude and divisor, flag quotients too large for the result
    always_comb
    begin
        mag = link_in.total[63] ? 64'(-link_in.total) : 64'(link_in.total);
        st_next[0].neg = link_in.total[63];
        st_next[0].rem = REM_W'(mag);
        st_next[0].den = {link_in.ampsum, 2'b00};
        st_next[0].ovf = st_next[0].rem >= (REM_W'(st_next[0].den) << QUO_W);
        st_next[0].quo = '0;
    end

    // One quotient bit per stage, most significant first
    for (genvar j = 1; j <= QUO_W; j++)
    begin : g_step
        localparam int B = QUO_W - j;
        logic [REM_W-1:0] shifted;
        always_comb
        begin
            shifted    = REM_W'(st_reg[j-1].den) << B;
            st_next[j] = st_reg[j-1];
            if (st_reg[j-1].rem >= shifted)
            begin
                st_next[j].rem    = st_reg[j-1].rem - shifted;
                st_next[j].quo[B] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[QUO_W-1:0], link_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg <= st_next;
        end
    end

    // Apply sign and saturate
    always_comb
    begin
        if (st_reg[QUO_W].neg)
        begin
            if (st_reg[QUO_W].ovf || st_reg[QUO_W].quo > 17'd32768)
            begin
                out_value = fbm_pkg::NOISE_MIN;
            end
            else
            begin
                out_value = fbm_pkg::NOISE_W'(17'd0 - st_reg[QUO_W].quo);
            end
        end
        else if (st_reg[QUO_W].ovf || st_reg[QUO_W].quo > 17'd32767)
        begin
            out_value = fbm_pkg::NOISE_MAX;
        end
        else
        begin
            out_value = st_reg[QUO_W].quo[15:0];
        end
    end

    assign out_valid = vld_reg[QUO_W];

endmodule

`default_nettype wire

### hdl/fbm_gradient_noise_3d.sv
// Pipeline: nine stages per octave cell, one operand stage plus 17 quotient stages in
// the divider, and the result register. Throughput: one sample request per cycle while
// the pipeline does not stall. The pipeline stalls only when the result register holds
// a result that is not taken (result.ready low) and the last divider stage is full.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the registers with
// 4 octaves, persistence 0.5, lacunarity 2.0, seed 0.
`default_nettype none

module fbm_gradient_noise_3d #(
    parameter int MAX_OCTAVES     = 8,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [fbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fbm_pkg::CFG_DATA_W-1:0]     cfg_data,
    fbm_stream_if.sink                         sample,
    fbm_stream_if.source                       result
);
    logic [fbm_pkg::OCT_W-1:0]      oct_cnt_reg;
    logic [fbm_pkg::PERSIST_W-1:0]  persist_reg;
    logic [fbm_pkg::LACUN_W-1:0]    lacun_reg;
    logic [fbm_pkg::SEED_W-1:0]     seed_reg;
    logic [fbm_pkg::OCT_W:0]        n_eff;
    logic [MAX_OCTAVES-1:0]         oct_active;

    fbm_pkg::octave_link_t          link [MAX_OCTAVES+1];
    logic                           adv;
    logic                           out_load;
    logic                           div_valid;
    logic signed [fbm_pkg::NOISE_W-1:0] div_value;
    logic                           res_valid_reg;
    fbm_pkg::result_t               res_data_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_cnt_reg <= 4'd4;
            persist_reg <= 17'd32768;
            lacun_reg   <= 20'd131072;
            seed_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (fbm_pkg::cfg_reg_t'(cfg_index))
                fbm_pkg::REG_OCTAVE_COUNT: oct_cnt_reg <= cfg_data[fbm_pkg::OCT_W-1:0];
                fbm_pkg::REG_PERSISTENCE:  persist_reg <= cfg_data[fbm_pkg::PERSIST_W-1:0];
                fbm_pkg::REG_LACUNARITY:   lacun_reg   <= cfg_data[fbm_pkg::LACUN_W-1:0];
                fbm_pkg::REG_HASH_SEED:    seed_reg    <= cfg_data[fbm_pkg::SEED_W-1:0];
            endcase
        end
    end

    // Clamp the octave count to one..MAX_OCTAVES
    always_comb
    begin
        if (oct_cnt_reg == '0)
        begin
            n_eff = (fbm_pkg::OCT_W+1)'(1);
        end
        else if ({1'b0, oct_cnt_reg} > (fbm_pkg::OCT_W+1)'(MAX_OCTAVES))
        begin
            n_eff = (fbm_pkg::OCT_W+1)'(MAX_OCTAVES);
        end
        else
        begin
            n_eff = {1'b0, oct_cnt_reg};
        end
    end

    // Hold the pipeline only when a finished request cannot leave
    assign out_load     = !res_valid_reg || result.ready;
    assign adv          = !div_valid || out_load;
    assign sample.ready = adv;

    always_comb
    begin
        link[0].valid  = sample.valid;
        link[0].pt     = sample.data;
        link[0].freq   = fbm_pkg::ONE_FREQ;
        link[0].amp    = fbm_pkg::ONE_AMP;
        link[0].total  = '0;
        link[0].ampsum = '0;
    end

    for (genvar k = 0; k < MAX_OCTAVES; k++)
    begin : g_oct
        assign oct_active[k] = (fbm_pkg::OCT_W+1)'(k) < n_eff;

        fbm_octave_cell #(
            .COORD_FRAC_BITS(COORD_FRAC_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .adv         (adv),
            .active      (oct_active[k]),
            .persistence (persist_reg),
            .lacunarity  (lacun_reg),
            .hash_seed   (seed_reg),
            .link_in     (link[k]),
            .link_out    (link[k+1])
        );
    end

    fbm_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .link_in   (link[MAX_OCTAVES]),
        .out_valid (div_valid),
        .out_value (div_value)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && div_valid)
        begin
            res_data_reg.noise_value <= div_value;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

endmodule

`default_nettype wire

### hdl/fbm_checker.sv
`default_nettype none

module fbm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_valid,
    input logic        s_ready,
    input logic        r_valid,
    input logic        r_ready,
    input logic [15:0] r_data
);
    logic [15:0] cnt_reg;
    logic [15:0] cnt_next;
    logic        s_acc;
    logic        r_acc;

    assign s_acc = s_valid && s_ready;
    assign r_acc = r_valid && r_ready;

    // Count requests taken in and not yet delivered
    always_comb
    begin
        cnt_next = cnt_reg;
        if (s_acc && !r_acc)
        begin
            cnt_next = cnt_reg + 16'd1;
        end
        else if (r_acc && !s_acc)
        begin
            cnt_next = cnt_reg - 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(r_data))
        else $error("result dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !r_valid)
        else $error("result valid right after reset");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> cnt_reg != 16'd0)
        else $error("result with no request outstanding");

    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 16'd0 && !s_acc |=> !r_valid)
        else $error("result appeared from an empty pipeline");

endmodule

bind fbm_gradient_noise_3d fbm_checker u_fbm_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (sample.valid),
    .s_ready (sample.ready),
    .r_valid (result.valid),
    .r_ready (result.ready),
    .r_data  (result.data.noise_value)
);

`default_nettype wire

### sim/fbm_gradient_noise_3d_tb.sv
module fbm_gradient_noise_3d_tb;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [fbm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [fbm_pkg::CFG_DATA_W-1:0] cfg_data;

    fbm_stream_if #(.data_t(fbm_pkg::sample_t)) sample_ch ();
    fbm_stream_if #(.data_t(fbm_pkg::result_t)) result_ch ();

    fbm_gradient_noise_3d u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .sample(sample_ch.sink),
        .result(result_ch.source)
    );

    // Local copy of the registers
    logic [fbm_pkg::OCT_W-1:0]     octaves_q;
    logic [fbm_pkg::PERSIST_W-1:0] persist_q;
    logic [fbm_pkg::LACUN_W-1:0]   lacun_q;
    logic [fbm_pkg::SEED_W-1:0]    seed_q;

    fbm_pkg::sample_t                   pending_samples[$];
    logic signed [fbm_pkg::NOISE_W-1:0] expected_noise[$];
    int mismatch_count;
    int result_count;
    int sample_count;
    bit hold_samples;
    bit idle_free;
    bit sample_taken;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [31:0] asr16(input logic [31:0] v);
        return {{16{v[31]}}, v[31:16]};
    endfunction

    function automatic logic [31:0] axis_scramble(input logic [31:0] v);
        logic [31:0] r;
        r = (asr16(v) ^ v) * 32'h045d9f3b;
        r = (asr16(r) ^ r) * 32'h045d9f3b;
        return asr16(r) ^ r;
    endfunction

    function automatic logic [31:0] lattice_hash(input logic [31:0] x, input logic [31:0] y,
                                                 input logic [31:0] z);
        return (axis_scramble(x) ^ axis_scramble(y) ^ axis_scramble(z)) + seed_q;
    endfunction

    function automatic longint quintic_fade(input longint a);
        longint t2;
        longint t3;
        longint p;
        t2 = (a * a) >>> 16;
        t3 = (t2 * a) >>> 16;
        p = 10 * 65536 + ((6 * a * a) >>> 16) - 15 * a;
        return (t3 * p) >>> 16;
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint t);
        return a + ((b - a) * t >>> 16);
    endfunction

    function automatic longint gradient_dot(input logic [31:0] h, input longint x,
                                            input longint y, input longint z);
        logic [3:0] g;
        longint u;
        longint v;
        g = h[3:0];
        u = (g < 8) ? x : y;
        v = (g < 4) ? y : ((g == 12 || g == 14) ? x : z);
        return (g[0] ? -u : u) + (g[1] ? -v : v);
    endfunction

    function automatic longint octave_noise(input longint sx, input longint sy,
                                            input longint sz);
        logic [31:0] xi;
        logic [31:0] yi;
        logic [31:0] zi;
        longint xf;
        longint yf;
        longint zf;
        longint u;
        longint v;
        longint w;
        longint a1;
        longint a2;
        longint b1;
        longint b2;
        xi = 32'(sx >>> 16);
        yi = 32'(sy >>> 16);
        zi = 32'(sz >>> 16);
        xf = sx & 64'hffff;
        yf = sy & 64'hffff;
        zf = sz & 64'hffff;
        u = quintic_fade(xf);
        v = quintic_fade(yf);
        w = quintic_fade(zf);
        a1 = blend(gradient_dot(lattice_hash(xi, yi, zi), xf, yf, zf),
                   gradient_dot(lattice_hash(xi + 1, yi, zi), xf - 65536, yf, zf), u);
        a2 = blend(gradient_dot(lattice_hash(xi, yi + 1, zi), xf, yf - 65536, zf),
                   gradient_dot(lattice_hash(xi + 1, yi + 1, zi), xf - 65536, yf - 65536,
                                zf), u);
        b1 = blend(gradient_dot(lattice_hash(xi, yi, zi + 1), xf, yf, zf - 65536),
                   gradient_dot(lattice_hash(xi + 1, yi, zi + 1), xf - 65536, yf,
                                zf - 65536), u);
        b2 = blend(gradient_dot(lattice_hash(xi, yi + 1, zi + 1), xf, yf - 65536,
                                zf - 65536),
                   gradient_dot(lattice_hash(xi + 1, yi + 1, zi + 1), xf - 65536,
                                yf - 65536, zf - 65536), u);
        return blend(blend(a1, a2, v), blend(b1, b2, v), w);
    endfunction

    function automatic logic signed [fbm_pkg::NOISE_W-1:0] fbm_noise(
        input fbm_pkg::sample_t s
    );
        longint n;
        longint unsigned freq;
        longint unsigned amp;
        longint unsigned ampsum;
        longint total;
        longint res;
        longint cx;
        longint cy;
        longint cz;
        cx = s.coord_x;
        cy = s.coord_y;
        cz = s.coord_z;
        n = octaves_q;
        if (n < 1)
            n = 1;
        if (n > 8)
            n = 8;
        freq = 65536;
        amp = 65536;
        ampsum = 0;
        total = 0;
        for (int i = 0; i < n; i++)
        begin
            longint f;
            f = longint'(freq);
            total += octave_noise((cx * f) >>> 16, (cy * f) >>> 16, (cz * f) >>> 16)
                     * longint'(amp);
            ampsum += amp;
            amp = (amp * persist_q) >> 16;
            if (amp > 64'd1099511627775)
                amp = 64'd1099511627775;
            freq = (freq * lacun_q) >> 16;
            if (freq > 64'd2147483647)
                freq = 64'd2147483647;
        end
        res = total / longint'(ampsum * 4);
        if (res > 32767)
            res = 32767;
        if (res < -32768)
            res = -32768;
        return res[15:0];
    endfunction

    // Write one register at a falling edge and mirror it
    task automatic write_reg(input fbm_pkg::cfg_reg_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            fbm_pkg::REG_OCTAVE_COUNT: octaves_q = value[fbm_pkg::OCT_W-1:0];
            fbm_pkg::REG_PERSISTENCE:  persist_q = value[fbm_pkg::PERSIST_W-1:0];
            fbm_pkg::REG_LACUNARITY:   lacun_q = value[fbm_pkg::LACUN_W-1:0];
            default:                   seed_q = value;
        endcase
    endtask

    task automatic set_all(input logic [31:0] oc, input logic [31:0] pe,
                           input logic [31:0] la, input logic [31:0] se);
        write_reg(fbm_pkg::REG_OCTAVE_COUNT, oc);
        write_reg(fbm_pkg::REG_PERSISTENCE, pe);
        write_reg(fbm_pkg::REG_LACUNARITY, la);
        write_reg(fbm_pkg::REG_HASH_SEED, se);
    endtask

    // Queue one request with its prediction under the current registers
    task automatic add_sample(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        fbm_pkg::sample_t s;
        s.coord_x = x;
        s.coord_y = y;
        s.coord_z = z;
        pending_samples = {pending_samples, s};
        expected_noise = {expected_noise, fbm_noise(s)};
    endtask

    // Drain the pipeline before touching registers
    task automatic wait_idle();
        while (pending_samples.size() != 0 || expected_noise.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
            default: return 32'($signed($urandom_range(0, 200)) - 100) << 16;
        endcase
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
            add_sample(rand_coord(), rand_coord(), rand_coord());
    endtask

    // Present requests at falling edges
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
        end
        else if (sample_ch.valid && !sample_taken)
        begin
            sample_ch.valid <= 1'b1;
        end
        else if (pending_samples.size() != 0 && !hold_samples &&
                 (idle_free || $urandom_range(0, 99) >= 13))
        begin
            sample_ch.valid <= 1'b1;
            sample_ch.data <= pending_samples[0];
        end
        else
        begin
            sample_ch.valid <= 1'b0;
        end
        result_ch.ready <= idle_free || $urandom_range(0, 99) >= 13;
    end

    // Pop the accepted request and check results at rising edges
    always @(posedge clk)
    begin
        sample_taken = rst_n && sample_ch.valid && sample_ch.ready;
        if (sample_taken)
        begin
            void'(pending_samples.pop_front());
            sample_count++;
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            result_count++;
            if (expected_noise.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result noise_value=%0d", result_ch.data.noise_value);
            end
            else
            begin
                logic signed [fbm_pkg::NOISE_W-1:0] exp_v;
                exp_v = expected_noise.pop_front();
                if (result_ch.data.noise_value !== exp_v)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("noise_value mismatch: expected %0d got %0d", exp_v,
                                 result_ch.data.noise_value);
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.data = '0;
        result_ch.ready = 1'b0;
        hold_samples = 1'b0;
        idle_free = 1'b0;
        sample_taken = 1'b0;
        mismatch_count = 0;
        result_count = 0;
        sample_count = 0;
        octaves_q = 4;
        persist_q = 32768;
        lacun_q = 131072;
        seed_q = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: coordinate extremes and lattice wrap under reset settings
        add_sample(32'h0, 32'h0, 32'h0);
        add_sample(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        add_sample(32'h80000000, 32'h80000000, 32'h80000000);
        add_sample(32'hffffffff, 32'h00000001, 32'h0000ffff);
        add_sample(32'h00010000, 32'hffff0000, 32'h00008000);
        add_sample(32'h7fff8000, 32'h80000001, 32'h12345678);
        add_sample(32'h0000ffff, 32'hffff0001, 32'hedcba987);
        wait_idle();

        // Zero octaves, zero persistence and lacunarity, full seed
        set_all(0, 0, 0, 32'hffffffff);
        add_sample(32'h00018000, 32'hfffe4000, 32'h7fffffff);
        add_sample(32'h80000000, 32'h7fffffff, 32'h00000000);
        add_sample(32'h00004000, 32'h0000c000, 32'h00002000);
        wait_idle();

        // Octaves above the limit, maximum factors: frequency saturates
        set_all(15, 131071, 1048575, 32'h5a5a5a5a);
        add_sample(32'h7fffffff, 32'h80000000, 32'h00010001);
        add_sample(32'h00000001, 32'hffffffff, 32'h00000000);
        add_sample(32'h12345678, 32'h9abcdef0, 32'h0fedcba9);
        add_sample(32'h00000000, 32'h00000000, 32'h00000000);
        wait_idle();

        // Eight octaves, one octave
        set_all(8, 65536, 65536, 32'h1);
        add_sample(32'h00028000, 32'h00030000, 32'hfffd0000);
        add_sample(32'hffffffff, 32'hffffffff, 32'hffffffff);
        wait_idle();
        set_all(1, 12345, 99999, 32'h80000000);
        add_sample(32'h00028000, 32'h00030000, 32'hfffd0000);
        add_sample(32'h55555555, 32'haaaaaaaa, 32'h33333333);

        // Pause the sender until every request already taken has its result, then resume
        repeat (4) @(posedge clk);
        hold_samples = 1'b1;
        while (expected_noise.size() != pending_samples.size())
            @(posedge clk);
        repeat (5) @(posedge clk);
        hold_samples = 1'b0;
        wait_idle();

        // Random phases over random and extreme settings
        for (int ph = 0; ph < 12; ph++)
        begin
            wait_idle();
            case (ph)
                0: set_all(4, 32768, 131072, 0);
                1: set_all(8, 131071, 1048575, 32'hffffffff);
                2: set_all(1, 0, 0, 0);
                default: set_all($urandom_range(0, 15), $urandom_range(0, 131071),
                                 $urandom_range(0, 1048575), $urandom);
            endcase
            idle_free = (ph == 5);
            random_phase(150);
        end
        idle_free = 1'b0;

        wait_idle();
        $display("Checked %0d noise results from %0d sample requests: directed corner",
                 result_count, sample_count);
        $display("points under five register sets, then twelve random register sets.");
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### fbm_gradient_noise_3d.f
hdl/fbm_pkg.sv
hdl/fbm_stream_if.sv
hdl/fbm_octave_cell.sv
hdl/fbm_div_pipe.sv
hdl/fbm_gradient_noise_3d.sv
hdl/fbm_checker.sv
sim/fbm_gradient_noise_3d_tb.sv
